FILE: rtl/core/hsm_pkg.sv
// types and constants for the module hot-swap state machine
// no dependencies; imported by module_hot_swap_state_machine
package hsm_pkg;

    // input item
    typedef struct packed {
        logic operation;
        logic handle_closed;
        logic power_good;
        logic user_ready;
        logic event_channel_ok;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [2:0] fru_state;
        logic       led_red;
        logic       led_green;
        logic       led_blue;
        logic       payload_enable;
        logic [1:0] events_sent;
        logic       event_value;
        logic [1:0] sensor_code;
        logic       periodic_due;
        logic       rtm_check_due;
    } out_item_t;

    // M states, one-hot
    typedef enum logic [6:0] {
        M0 = 7'b0000001,
        M1 = 7'b0000010,
        M2 = 7'b0000100,
        M3 = 7'b0001000,
        M4 = 7'b0010000,
        M5 = 7'b0100000,
        M6 = 7'b1000000
    } mstate_t;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PASS = 1'b1;

    // sensor codes
    localparam logic [1:0] SENS_CLOSED = 2'd1;
    localparam logic [1:0] SENS_OPEN   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_IN_CRATE    = 2'd0;
    localparam logic [1:0] REG_ACT_BLINK   = 2'd1;
    localparam logic [1:0] REG_DEACT_BLINK = 2'd2;
    localparam logic [1:0] REG_TICK_DIVIDE = 2'd3;

    localparam int          APB_ADDR_W        = 4;
    localparam logic        IN_CRATE_RESET    = 1'b1;
    localparam logic [3:0]  ACT_BLINK_RESET   = 4'd10;
    localparam logic [3:0]  DEACT_BLINK_RESET = 4'd2;
    localparam logic [7:0]  TICK_DIVIDE_RESET = 8'd100;

    function automatic logic [2:0] mstate_num(mstate_t s);
        logic [2:0] n;
        n = 3'd0;
        unique case (s)
            M0: n = 3'd0;
            M1: n = 3'd1;
            M2: n = 3'd2;
            M3: n = 3'd3;
            M4: n = 3'd4;
            M5: n = 3'd5;
            M6: n = 3'd6;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/core/module_hot_swap_state_machine.sv
// module hot-swap controller, states M0 to M6, with APB register port
// depends on hsm_pkg
//
// usage:
//   in channel: in_valid / in_ready / in_data. operation 0 is a timer tick
//   (samples the handle, advances the period divider and blink counter),
//   operation 1 is a main-loop pass (one step of the M-state machine).
//   out channel: out_valid / out_ready / out_data, one result item per item.
//   result: registered, it appears in the cycle after the item is accepted.
//   throughput: one item per clock while results are taken; all the work of an
//   item is one level of state update logic feeding the result register.
//   a stalled receiver holds the result register; a new item is still taken
//   in the cycle the held result is taken (in_ready = !out_valid | out_ready).
//   config: APB writes at byte addresses 0 in_crate, 4 act_blink,
//   8 deact_blink, 12 tick_divide; pready is always high, reads return the
//   register value. write only while the block is idle.
//   reset (rst_n low, async): state M0, LEDs and payload power off, sensor
//   open, counters cleared, registers back to 1 / 10 / 2 / 100, no result.
module module_hot_swap_state_machine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hsm_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hsm_pkg::out_item_t          out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import hsm_pkg::*;

    // configuration
    logic       in_crate_reg;
    logic [3:0] act_blink_reg;
    logic [3:0] deact_blink_reg;
    logic [7:0] tick_divide_reg;
    logic       cfg_write;

    // controller state
    mstate_t    mode_reg, mode_next;
    logic       handle_now_reg, handle_now_next;
    logic       handle_rec_reg, handle_rec_next;
    logic [1:0] sensor_reg, sensor_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [7:0] tick_inc;
    logic [3:0] blink_count_reg, blink_count_next;
    logic       blink_flag_reg, blink_flag_next;
    logic       init_done_reg, init_done_next;
    logic       pending_reg, pending_next;
    logic       red_reg, red_next;
    logic       green_reg, green_next;
    logic       blue_reg, blue_next;
    logic       power_reg, power_next;
    logic [1:0] events;
    logic       periodic;
    logic       rtm;

    out_item_t  out_reg, out_next;
    logic       out_valid_reg;
    logic       accept;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_crate_reg    <= IN_CRATE_RESET;
            act_blink_reg   <= ACT_BLINK_RESET;
            deact_blink_reg <= DEACT_BLINK_RESET;
            tick_divide_reg <= TICK_DIVIDE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_IN_CRATE:    in_crate_reg    <= pwdata[0];
                REG_ACT_BLINK:   act_blink_reg   <= pwdata[3:0];
                REG_DEACT_BLINK: deact_blink_reg <= pwdata[3:0];
                REG_TICK_DIVIDE: tick_divide_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            REG_IN_CRATE:    prdata = {31'd0, in_crate_reg};
            REG_ACT_BLINK:   prdata = {28'd0, act_blink_reg};
            REG_DEACT_BLINK: prdata = {28'd0, deact_blink_reg};
            REG_TICK_DIVIDE: prdata = {24'd0, tick_divide_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign tick_inc = tick_count_reg + 8'd1;

    always_comb
    begin
        mode_next        = mode_reg;
        handle_now_next  = handle_now_reg;
        handle_rec_next  = handle_rec_reg;
        sensor_next      = sensor_reg;
        tick_count_next  = tick_count_reg;
        blink_count_next = blink_count_reg;
        blink_flag_next  = blink_flag_reg;
        init_done_next   = init_done_reg;
        pending_next     = pending_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        power_next       = power_reg;
        events           = 2'd0;
        periodic         = 1'b0;
        rtm              = 1'b0;

        if (in_data.operation == OP_TICK)
        begin
            handle_now_next = in_data.handle_closed;
            tick_count_next = tick_inc;
            if (tick_inc == tick_divide_reg)
            begin
                pending_next    = 1'b1;
                tick_count_next = 8'd0;
                if (blink_count_reg != 4'd0)
                begin
                    blink_count_next = blink_count_reg - 4'd1;
                    blink_flag_next  = 1'b0;
                end
                else
                begin
                    blink_flag_next = 1'b1;
                end
            end
        end
        else
        begin
            // one-time initial hot-swap event
            if (!init_done_reg && in_data.event_channel_ok)
            begin
                events         = events + 2'd1;
                init_done_next = 1'b1;
            end

            unique case (mode_reg)
                M0:
                begin
                    green_next = 1'b0;
                    if (in_crate_reg)
                        mode_next = M1;
                end
                M1:
                begin
                    red_next   = 1'b1;
                    green_next = 1'b0;
                    blue_next  = 1'b1;
                    power_next = 1'b0;
                    if (handle_now_reg || handle_rec_reg)
                    begin
                        handle_rec_next = handle_now_reg;
                        if (handle_now_reg)
                        begin
                            sensor_next      = SENS_CLOSED;
                            mode_next        = M2;
                            blink_count_next = act_blink_reg;
                        end
                        else
                        begin
                            sensor_next = SENS_OPEN;
                        end
                        events = events + 2'd1;
                    end
                end
                M2:
                begin
                    if (blink_flag_reg)
                    begin
                        blue_next        = !blue_reg;
                        blink_flag_next  = 1'b0;
                        blink_count_next = act_blink_reg;
                        events           = events + 2'd1;
                    end
                    if (in_data.power_good)
                    begin
                        power_next = 1'b1;
                        mode_next  = M3;
                    end
                    else if (handle_now_reg != handle_rec_reg)
                    begin
                        // sensor state left as is on the way back to M1
                        handle_rec_next = handle_now_reg;
                        mode_next       = M1;
                        events          = events + 2'd1;
                    end
                end
                M3, M4:
                begin
                    // M3 falls through into the M4 step
                    if (mode_reg == M3 && in_data.user_ready)
                        mode_next = M4;
                    blue_next  = 1'b0;
                    red_next   = 1'b0;
                    green_next = 1'b1;
                    if (handle_now_reg != handle_rec_reg)
                    begin
                        handle_rec_next = handle_now_reg;
                        if (handle_now_reg)
                        begin
                            sensor_next = SENS_CLOSED;
                            mode_next   = M4;
                        end
                        else
                        begin
                            sensor_next      = SENS_OPEN;
                            mode_next        = M5;
                            blink_count_next = deact_blink_reg;
                            blink_flag_next  = 1'b0;
                        end
                        events = events + 2'd1;
                    end
                    if (!in_data.power_good)
                        mode_next = M5;
                end
                M5:
                begin
                    power_next = 1'b0;
                    if (blink_flag_reg)
                    begin
                        blue_next        = !blue_reg;
                        blink_flag_next  = 1'b0;
                        blink_count_next = deact_blink_reg;
                    end
                    mode_next = M6;
                end
                M6:
                begin
                    if (blink_flag_reg)
                    begin
                        blue_next        = !blue_reg;
                        blink_flag_next  = 1'b0;
                        blink_count_next = deact_blink_reg;
                    end
                    if (!in_data.power_good)
                        mode_next = M1;
                end
                default:
                begin
                    mode_next = M0;
                end
            endcase

            periodic     = pending_reg;
            rtm          = pending_reg && (mode_next == M4);
            pending_next = 1'b0;
        end

        out_next.fru_state      = mstate_num(mode_next);
        out_next.led_red        = red_next;
        out_next.led_green      = green_next;
        out_next.led_blue       = blue_next;
        out_next.payload_enable = power_next;
        out_next.events_sent    = events;
        out_next.event_value    = (events != 2'd0) ? handle_now_next : 1'b0;
        out_next.sensor_code    = sensor_next;
        out_next.periodic_due   = periodic;
        out_next.rtm_check_due  = rtm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M0;
            handle_now_reg  <= 1'b0;
            handle_rec_reg  <= 1'b0;
            sensor_reg      <= SENS_OPEN;
            tick_count_reg  <= 8'd0;
            blink_count_reg <= 4'd0;
            blink_flag_reg  <= 1'b0;
            init_done_reg   <= 1'b0;
            pending_reg     <= 1'b0;
            red_reg         <= 1'b0;
            green_reg       <= 1'b0;
            blue_reg        <= 1'b0;
            power_reg       <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            handle_now_reg  <= handle_now_next;
            handle_rec_reg  <= handle_rec_next;
            sensor_reg      <= sensor_next;
            tick_count_reg  <= tick_count_next;
            blink_count_reg <= blink_count_next;
            blink_flag_reg  <= blink_flag_next;
            init_done_reg   <= init_done_next;
            pending_reg     <= pending_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
            power_reg       <= power_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: dv/module_hot_swap_state_machine_tb.sv
// self-checking testbench for module_hot_swap_state_machine
// depends on hsm_pkg and the block; a local predictor checks every result item
module module_hot_swap_state_machine_tb;

    import hsm_pkg::*;

    localparam logic [2:0] FRU_M0 = 3'd0;
    localparam logic [2:0] FRU_M1 = 3'd1;
    localparam logic [2:0] FRU_M2 = 3'd2;
    localparam logic [2:0] FRU_M3 = 3'd3;
    localparam logic [2:0] FRU_M4 = 3'd4;
    localparam logic [2:0] FRU_M5 = 3'd5;
    localparam logic [2:0] FRU_M6 = 3'd6;

    localparam int QUIET_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state
    logic [2:0] fru_mode;
    logic       hdl_now;
    logic       hdl_rec;
    logic [1:0] sens_state;
    logic [7:0] tick_cnt;
    logic [3:0] blink_cnt;
    logic       blink_due;
    logic       init_sent;
    logic       period_due;
    logic       led_r;
    logic       led_g;
    logic       led_b;
    logic       pwr_on;

    // predictor copy of the registers
    logic       cfg_in_crate;
    logic [3:0] cfg_act_blink;
    logic [3:0] cfg_deact_blink;
    logic [7:0] cfg_tick_div;

    out_item_t expected_results[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        rx_hold_req = 0;
    logic      tx_idle_on = 1'b1;
    logic      rx_idle_on = 1'b1;
    logic      handle_pos = 1'b0;
    logic      supply_pos = 1'b1;

    module_hot_swap_state_machine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void model_reset();
        cfg_in_crate    = IN_CRATE_RESET;
        cfg_act_blink   = ACT_BLINK_RESET;
        cfg_deact_blink = DEACT_BLINK_RESET;
        cfg_tick_div    = TICK_DIVIDE_RESET;
        fru_mode   = FRU_M0;
        hdl_now    = 1'b0;
        hdl_rec    = 1'b0;
        sens_state = SENS_OPEN;
        tick_cnt   = 8'd0;
        blink_cnt  = 4'd0;
        blink_due  = 1'b0;
        init_sent  = 1'b0;
        period_due = 1'b0;
        led_r      = 1'b0;
        led_g      = 1'b0;
        led_b      = 1'b0;
        pwr_on     = 1'b0;
    endfunction

    function automatic void blink_toggle(logic [3:0] reload);
        if (blink_due)
        begin
            led_b     = !led_b;
            blink_due = 1'b0;
            blink_cnt = reload;
        end
    endfunction

    // one tick or loop pass; returns the result item it causes
    function automatic out_item_t hot_swap_step(in_item_t it);
        out_item_t  r;
        logic [1:0] events;
        logic       periodic;
        logic       rtm;
        events   = 2'd0;
        periodic = 1'b0;
        rtm      = 1'b0;
        if (it.operation == OP_TICK)
        begin
            hdl_now  = it.handle_closed;
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt == cfg_tick_div)
            begin
                period_due = 1'b1;
                tick_cnt   = 8'd0;
                if (blink_cnt != 4'd0)
                begin
                    blink_cnt = blink_cnt - 4'd1;
                    blink_due = 1'b0;
                end
                else
                begin
                    blink_due = 1'b1;
                end
            end
        end
        else
        begin
            if (!init_sent && it.event_channel_ok)
            begin
                events    = events + 2'd1;
                init_sent = 1'b1;
            end
            case (fru_mode)
                FRU_M0:
                begin
                    led_g = 1'b0;
                    if (cfg_in_crate)
                        fru_mode = FRU_M1;
                end
                FRU_M1:
                begin
                    led_r  = 1'b1;
                    led_g  = 1'b0;
                    led_b  = 1'b1;
                    pwr_on = 1'b0;
                    if (hdl_now != hdl_rec || hdl_now)
                    begin
                        hdl_rec = hdl_now;
                        if (hdl_now)
                        begin
                            sens_state = SENS_CLOSED;
                            fru_mode   = FRU_M2;
                            blink_cnt  = cfg_act_blink;
                        end
                        else
                        begin
                            sens_state = SENS_OPEN;
                        end
                        events = events + 2'd1;
                    end
                end
                FRU_M2:
                begin
                    if (blink_due)
                    begin
                        blink_toggle(cfg_act_blink);
                        events = events + 2'd1;
                    end
                    if (it.power_good)
                    begin
                        pwr_on   = 1'b1;
                        fru_mode = FRU_M3;
                    end
                    else if (hdl_now != hdl_rec)
                    begin
                        // sensor state is left as it was on this return
                        hdl_rec  = hdl_now;
                        fru_mode = FRU_M1;
                        events   = events + 2'd1;
                    end
                end
                FRU_M3, FRU_M4:
                begin
                    // m3 runs the m4 checks in the same pass
                    if (fru_mode == FRU_M3 && it.user_ready)
                        fru_mode = FRU_M4;
                    led_b = 1'b0;
                    led_r = 1'b0;
                    led_g = 1'b1;
                    if (hdl_now != hdl_rec)
                    begin
                        hdl_rec = hdl_now;
                        if (hdl_now)
                        begin
                            sens_state = SENS_CLOSED;
                            fru_mode   = FRU_M4;
                        end
                        else
                        begin
                            sens_state = SENS_OPEN;
                            fru_mode   = FRU_M5;
                            blink_cnt  = cfg_deact_blink;
                            blink_due  = 1'b0;
                        end
                        events = events + 2'd1;
                    end
                    if (!it.power_good)
                        fru_mode = FRU_M5;
                end
                FRU_M5:
                begin
                    pwr_on = 1'b0;
                    blink_toggle(cfg_deact_blink);
                    fru_mode = FRU_M6;
                end
                FRU_M6:
                begin
                    blink_toggle(cfg_deact_blink);
                    if (!it.power_good)
                        fru_mode = FRU_M1;
                end
                default:
                begin
                    fru_mode = FRU_M0;
                end
            endcase
            periodic   = period_due;
            rtm        = period_due && (fru_mode == FRU_M4);
            period_due = 1'b0;
        end
        r.fru_state      = fru_mode;
        r.led_red        = led_r;
        r.led_green      = led_g;
        r.led_blue       = led_b;
        r.payload_enable = pwr_on;
        r.events_sent    = events;
        r.event_value    = (events != 2'd0) ? hdl_now : 1'b0;
        r.sensor_code    = sens_state;
        r.periodic_due   = periodic;
        r.rtm_check_due  = rtm;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic in_item_t tick_item(logic handle);
        in_item_t it;
        it.operation        = OP_TICK;
        it.handle_closed    = handle;
        it.power_good       = 1'($urandom_range(0, 1));
        it.user_ready       = 1'($urandom_range(0, 1));
        it.event_channel_ok = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t loop_pass_item(logic pgood, logic uready, logic chan);
        in_item_t it;
        it.operation        = OP_PASS;
        it.handle_closed    = 1'($urandom_range(0, 1));
        it.power_good       = pgood;
        it.user_ready       = uready;
        it.event_channel_ok = chan;
        return it;
    endfunction

    // handle and supply move slowly, with an occasional glitch on one item
    function automatic in_item_t session_item(int tick_pct);
        in_item_t it;
        if ($urandom_range(0, 99) < 4)
            handle_pos = !handle_pos;
        if ($urandom_range(0, 99) < (supply_pos ? 2 : 10))
            supply_pos = !supply_pos;
        it.operation        = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_PASS;
        it.handle_closed    = ($urandom_range(0, 99) < 5) ? !handle_pos : handle_pos;
        it.power_good       = ($urandom_range(0, 99) < 5) ? !supply_pos : supply_pos;
        it.user_ready       = 1'($urandom_range(0, 1));
        it.event_channel_ok = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic offer_item(input in_item_t it);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_IN_CRATE:    cfg_in_crate    = val[0];
            REG_ACT_BLINK:   cfg_act_blink   = val[3:0];
            REG_DEACT_BLINK: cfg_deact_blink = val[3:0];
            REG_TICK_DIVIDE: cfg_tick_div    = val[7:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // m0 held without in_crate, initial event, periodic flag in m0
    task automatic test_crate_hold();
        drain_results();
        reg_write(REG_IN_CRATE, 32'd0);
        reg_write(REG_TICK_DIVIDE, 32'd1);
        reg_write(REG_ACT_BLINK, 32'd1);
        reg_write(REG_DEACT_BLINK, 32'd0);
        offer_item(loop_pass_item(1'b1, 1'b1, 1'b0));
        offer_item(loop_pass_item(1'b0, 1'b0, 1'b1));
        offer_item(tick_item(1'b1));
        offer_item(loop_pass_item(1'b1, 1'b1, 1'b1));
        drain_results();
        reg_write(REG_IN_CRATE, 32'd1);
    endtask

    // insertion, blink countdown and toggle, return from m2 to m1
    task automatic test_insert_and_blink();
        offer_item(loop_pass_item(1'b0, 1'b0, 1'b0));
        offer_item(loop_pass_item(1'b0, 1'b0, 1'b0));
        offer_item(tick_item(1'b1));
        offer_item(tick_item(1'b1));
        offer_item(loop_pass_item(1'b0, 1'b0, 1'b0));
        offer_item(tick_item(1'b0));
        offer_item(loop_pass_item(1'b0, 1'b0, 1'b0));
        offer_item(loop_pass_item(1'b0, 1'b0, 1'b0));
    endtask

    // activation, m3 fall-through, extraction through m5 and m6
    task automatic test_activate_and_extract();
        offer_item(tick_item(1'b1));
        offer_item(loop_pass_item(1'b1, 1'b0, 1'b1));
        offer_item(loop_pass_item(1'b1, 1'b0, 1'b1));
        offer_item(loop_pass_item(1'b1, 1'b0, 1'b0));
        offer_item(loop_pass_item(1'b1, 1'b1, 1'b0));
        offer_item(tick_item(1'b0));
        offer_item(loop_pass_item(1'b1, 1'b1, 1'b1));
        offer_item(tick_item(1'b0));
        offer_item(loop_pass_item(1'b1, 1'b0, 1'b0));
        offer_item(tick_item(1'b0));
        offer_item(loop_pass_item(1'b1, 1'b0, 1'b0));
        offer_item(loop_pass_item(1'b0, 1'b0, 1'b0));
        offer_item(tick_item(1'b1));
        offer_item(loop_pass_item(1'b0, 1'b0, 1'b0));
        offer_item(loop_pass_item(1'b1, 1'b0, 1'b0));
        offer_item(loop_pass_item(1'b0, 1'b1, 1'b0));
    endtask

    // receiver holds off while items keep coming, then the sender waits
    task automatic test_receiver_hold();
        int n;
        tx_idle_on  = 1'b0;
        rx_hold_req = 120;
        for (n = 0; n < 24; n++)
            offer_item(session_item(50));
        drain_results();
        tx_idle_on = 1'b1;
    endtask

    task automatic run_session(input logic crate, input logic [3:0] blk_long,
                               input logic [3:0] blk_short, input logic [7:0] divide,
                               input int count, input int tick_pct);
        int n;
        drain_results();
        reg_write(REG_IN_CRATE, {31'd0, crate});
        reg_write(REG_ACT_BLINK, {28'd0, blk_long});
        reg_write(REG_DEACT_BLINK, {28'd0, blk_short});
        reg_write(REG_TICK_DIVIDE, {24'd0, divide});
        for (n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            offer_item(session_item(tick_pct));
        end
    endtask

    // divide 0 wraps the tick count; going from 255 down to 0 and then 100
    // also lowers the divide below a running count
    task automatic test_random_sessions();
        run_session(1'b1, 4'd0, 4'd0, 8'd1, 150, 50);
        run_session(1'b1, 4'd3, 4'd5, 8'd2, 150, 50);
        run_session(1'b1, 4'd15, 4'd15, 8'd255, 250, 90);
        run_session(1'b0, 4'd7, 4'd1, 8'd0, 250, 90);
        run_session(IN_CRATE_RESET, ACT_BLINK_RESET, DEACT_BLINK_RESET,
                    TICK_DIVIDE_RESET, 60, 70);
    endtask

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 30)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result item with none expected, expected none got %h",
                             $time, out_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("fru_state", 32'(want.fru_state),
                                32'(out_data.fru_state));
                    check_field("led_red", 32'(want.led_red), 32'(out_data.led_red));
                    check_field("led_green", 32'(want.led_green),
                                32'(out_data.led_green));
                    check_field("led_blue", 32'(want.led_blue), 32'(out_data.led_blue));
                    check_field("payload_enable", 32'(want.payload_enable),
                                32'(out_data.payload_enable));
                    check_field("events_sent", 32'(want.events_sent),
                                32'(out_data.events_sent));
                    check_field("event_value", 32'(want.event_value),
                                32'(out_data.event_value));
                    check_field("sensor_code", 32'(want.sensor_code),
                                32'(out_data.sensor_code));
                    check_field("periodic_due", 32'(want.periodic_due),
                                32'(out_data.periodic_due));
                    check_field("rtm_check_due", 32'(want.rtm_check_due),
                                32'(out_data.rtm_check_due));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(hot_swap_step(in_data));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        model_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_crate_hold();
        test_insert_and_blink();
        test_activate_and_extract();
        test_receiver_hold();
        test_random_sessions();
        drain_results();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
